// ===== src/md5sh_pkg.sv =====
// Shared types, constants and round functions for the MD5 stream hasher.
`timescale 1ns / 1ps

package md5sh_pkg;

    typedef logic [3:0][31:0] md5sh_words_t;

    typedef struct packed {
        logic start;
        logic init;
    } md5sh_ctrl_t;

    localparam logic [31:0] MD5_IV_A = 32'h67452301;
    localparam logic [31:0] MD5_IV_B = 32'hefcdab89;
    localparam logic [31:0] MD5_IV_C = 32'h98badcfe;
    localparam logic [31:0] MD5_IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] LAST_POS  = 6'd63;

    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] MD5_ROT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Message word index used by round r.
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] r4;
        logic [3:0] idx;
        r4 = r[3:0];
        case (r[5:4])
            2'd0:    idx = r4;
            2'd1:    idx = r4 * 4'd5 + 4'd1;
            2'd2:    idx = r4 * 4'd3 + 4'd5;
            2'd3:    idx = r4 * 4'd7;
            default: idx = r4;
        endcase
        return idx;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] t;
        t = {x, x} << s;
        return t[63:32];
    endfunction

endpackage

// ===== src/md5_stream_hasher.sv =====
// Top level of the MD5 stream hasher: block fill, padding sequencer and result register.
//
//  channel | ports                 | contents
//  --------+-----------------------+---------------------------------------------
//  in      | s_tvalid/s_tready     | s_tdata[7:0] data_byte, s_tuser has_byte,
//          |                       | s_tlast end_of_message
//  out     | m_tvalid/m_tready     | m_tdata[127:0] digest_a, b, c, d (a lowest)
//
// The transfer that completes a 64-byte block is followed by compression (one
// round per cycle plus buffer read latency and the chaining add), during which
// s_tready is low.
// Message end writes the padding one byte per cycle up to byte 63, then compresses;
// a second block of padding and compression follows when fewer than 9 bytes were free.
// aresetn clears the sequencer, counters and the output valid, and loads the chaining words with the MD5 IV.
// The result register frees the input side; a new digest waits only if it is still full.
`timescale 1ns / 1ps

module md5_stream_hasher
    import md5sh_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] has_byte
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // [31:0] digest_a, [63:32] digest_b,
                                    // [95:64] digest_c, [127:96] digest_d
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ZERO,
        ST_LEN,
        ST_COMP,
        ST_OUT
    } state_t;

    state_t       state_reg, state_next;
    state_t       ret_reg, ret_next;
    logic [5:0]   fill_reg, fill_next;
    logic [60:0]  byte_cnt_reg, byte_cnt_next;
    logic         m_tvalid_reg, m_tvalid_next;
    logic [127:0] m_tdata_reg, m_tdata_next;

    md5sh_ctrl_t  ctrl;
    logic         buf_we;
    logic [7:0]   buf_wdata;
    logic [3:0]   buf_raddr;
    logic [31:0]  buf_rdata;
    logic         core_done;
    md5sh_words_t chain;
    logic [63:0]  bit_count;
    logic         accept;
    logic         out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign bit_count = {byte_cnt_reg, 3'b000};
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        fill_next     = fill_reg;
        byte_cnt_next = byte_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        ctrl          = '0;
        buf_we        = 1'b0;
        buf_wdata     = '0;

        case (state_reg)
            ST_IDLE: begin
                buf_wdata = s_tdata;
                if (accept) begin
                    if (s_tuser) begin
                        buf_we        = 1'b1;
                        fill_next     = fill_reg + 6'd1;
                        byte_cnt_next = byte_cnt_reg + 61'd1;
                    end
                    if (s_tuser && fill_reg == LAST_POS) begin
                        ctrl.start = 1'b1;
                        state_next = ST_COMP;
                        ret_next   = s_tlast ? ST_PAD : ST_IDLE;
                    end else if (s_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                buf_we     = 1'b1;
                buf_wdata  = PAD_BYTE;
                fill_next  = fill_reg + 6'd1;
                state_next = ST_ZERO;
                if (fill_reg == LAST_POS) begin
                    ctrl.start = 1'b1;
                    state_next = ST_COMP;
                    ret_next   = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (fill_reg == LEN_START) begin
                    state_next = ST_LEN;
                end else begin
                    buf_we    = 1'b1;
                    fill_next = fill_reg + 6'd1;
                    if (fill_reg == LAST_POS) begin
                        ctrl.start = 1'b1;
                        state_next = ST_COMP;
                        ret_next   = ST_ZERO;
                    end
                end
            end
            ST_LEN: begin
                buf_we    = 1'b1;
                buf_wdata = bit_count[{fill_reg[2:0], 3'b000} +: 8];
                fill_next = fill_reg + 6'd1;
                if (fill_reg == LAST_POS) begin
                    ctrl.start = 1'b1;
                    state_next = ST_COMP;
                    ret_next   = ST_OUT;
                end
            end
            ST_COMP: begin
                if (core_done) begin
                    state_next = ret_reg;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = chain;
                    ctrl.init     = 1'b1;
                    fill_next     = '0;
                    byte_cnt_next = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ret_reg      <= ST_IDLE;
            fill_reg     <= '0;
            byte_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            fill_reg     <= fill_next;
            byte_cnt_reg <= byte_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    md5sh_buf u_buf (
        .aclk  (aclk),
        .we    (buf_we),
        .waddr (fill_reg),
        .wdata (buf_wdata),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    md5sh_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .ram_raddr (buf_raddr),
        .ram_rdata (buf_rdata),
        .done      (core_done),
        .chain     (chain)
    );

endmodule

// ===== src/md5sh_buf.sv =====
// Block buffer: 16 words of 4 byte lanes, byte write, registered word read.
`timescale 1ns / 1ps

module md5sh_buf (
    input  logic        aclk,
    input  logic        we,
    input  logic [5:0]  waddr,
    input  logic [7:0]  wdata,
    input  logic [3:0]  raddr,
    output logic [31:0] rdata
);

    logic [3:0][7:0] mem [16];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr[5:2]][waddr[1:0]] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/md5sh_core.sv =====
// MD5 compression engine: one round per cycle, message words read from the block buffer.
`timescale 1ns / 1ps

module md5sh_core
    import md5sh_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  md5sh_ctrl_t  ctrl,
    output logic [3:0]   ram_raddr,
    input  logic [31:0]  ram_rdata,
    output logic         done,
    output md5sh_words_t chain
);

    localparam logic [6:0] STEP_KM_FIRST = 7'd1;
    localparam logic [6:0] STEP_KM_LAST  = 7'd64;
    localparam logic [6:0] STEP_RND_FIRST = 7'd2;
    localparam logic [6:0] STEP_RND_LAST  = 7'd65;
    localparam logic [6:0] STEP_DONE     = 7'd66;

    logic         active_reg;
    logic [6:0]   step_reg;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg;
    logic [31:0]  km_reg;
    md5sh_words_t chain_reg;

    logic [5:0]   km_idx;
    logic [5:0]   rnd;
    logic [31:0]  f;
    logic [31:0]  sum;
    logic [31:0]  b_new;

    // Read for round s is issued at step s; the registered word plus K is held in km_reg, from which the round runs.
    assign ram_raddr = msg_index(step_reg[5:0]);
    assign km_idx    = 6'(step_reg - STEP_KM_FIRST);
    assign rnd       = 6'(step_reg - STEP_RND_FIRST);
    assign done      = active_reg && (step_reg == STEP_DONE);
    assign chain     = chain_reg;

    always_comb begin
        case (rnd[5:4])
            2'd0:    f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    f = b_reg ^ c_reg ^ d_reg;
            2'd3:    f = c_reg ^ (b_reg | ~d_reg);
            default: f = '0;
        endcase
        sum   = a_reg + f + km_reg;
        b_new = b_reg + rotl32(sum, MD5_ROT[{rnd[5:4], rnd[1:0]}]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            step_reg   <= '0;
            chain_reg  <= {MD5_IV_D, MD5_IV_C, MD5_IV_B, MD5_IV_A};
        end else if (ctrl.init) begin
            chain_reg <= {MD5_IV_D, MD5_IV_C, MD5_IV_B, MD5_IV_A};
        end else if (ctrl.start) begin
            active_reg <= 1'b1;
            step_reg   <= '0;
            a_reg      <= chain_reg[0];
            b_reg      <= chain_reg[1];
            c_reg      <= chain_reg[2];
            d_reg      <= chain_reg[3];
        end else if (active_reg) begin
            step_reg <= step_reg + 7'd1;
            if (step_reg >= STEP_KM_FIRST && step_reg <= STEP_KM_LAST) begin
                km_reg <= ram_rdata + MD5_K[km_idx];
            end
            if (step_reg >= STEP_RND_FIRST && step_reg <= STEP_RND_LAST) begin
                a_reg <= d_reg;
                b_reg <= b_new;
                c_reg <= b_reg;
                d_reg <= c_reg;
            end
            if (step_reg == STEP_DONE) begin
                active_reg   <= 1'b0;
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
            end
        end
    end

endmodule

// ===== dv/md5_digest_checker.sv =====
// Stream monitor for the MD5 hasher: predicts each digest and compares it with the result channel.
`timescale 1ns / 1ps

module md5_digest_checker
    import md5sh_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] has_byte
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,   // [31:0] digest_a, [63:32] digest_b,
                                    // [95:64] digest_c, [127:96] digest_d
    output int           n_errors,
    output int           n_pending,
    output int           n_digests
);

    localparam logic [0:63][31:0] ROUND_K = {
        32'd3614090360, 32'd3905402710, 32'd606105819,  32'd3250441966,
        32'd4118548399, 32'd1200080426, 32'd2821735955, 32'd4249261313,
        32'd1770035416, 32'd2336552879, 32'd4294925233, 32'd2304563134,
        32'd1804603682, 32'd4254626195, 32'd2792965006, 32'd1236535329,
        32'd4129170786, 32'd3225465664, 32'd643717713,  32'd3921069994,
        32'd3593408605, 32'd38016083,   32'd3634488961, 32'd3889429448,
        32'd568446438,  32'd3275163606, 32'd4107603335, 32'd1163531501,
        32'd2850285829, 32'd4243563512, 32'd1735328473, 32'd2368359562,
        32'd4294588738, 32'd2272392833, 32'd1839030562, 32'd4259657740,
        32'd2763975236, 32'd1272893353, 32'd4139469664, 32'd3200236656,
        32'd681279174,  32'd3936430074, 32'd3572445317, 32'd76029189,
        32'd3654602809, 32'd3873151461, 32'd530742520,  32'd3299628645,
        32'd4096336452, 32'd1126891415, 32'd2878612391, 32'd4237533241,
        32'd1700485571, 32'd2399980690, 32'd4293915773, 32'd2240044497,
        32'd1873313359, 32'd4264355552, 32'd2734768916, 32'd1309151649,
        32'd4149444226, 32'd3174756917, 32'd718787259,  32'd3951481745
    };

    localparam logic [0:15][4:0] ROT_AMT = {
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam md5sh_words_t START_CHAIN =
        {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

    // running hash state; block byte k lives at blk[8k +: 8], so word g is blk[32g +: 32]
    md5sh_words_t chain;
    logic [511:0] blk;
    logic [5:0]   fill;
    logic [63:0]  nbits;

    md5sh_words_t digest_q[$];

    function automatic md5sh_words_t md5_compress(input md5sh_words_t h,
                                                  input logic [511:0] block);
        logic [31:0]  a, b, c, d, f, t, sum;
        int           g, s, r;
        md5sh_words_t nxt;
        a = h[0];
        b = h[1];
        c = h[2];
        d = h[3];
        for (r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (5 * r + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            s   = int'(ROT_AMT[(r / 16) * 4 + r % 4]);
            sum = a + f + ROUND_K[r] + block[32 * g +: 32];
            t   = d;
            d   = c;
            c   = b;
            b   = b + ((sum << s) | (sum >> (32 - s)));
            a   = t;
        end
        nxt[0] = h[0] + a;
        nxt[1] = h[1] + b;
        nxt[2] = h[2] + c;
        nxt[3] = h[3] + d;
        return nxt;
    endfunction

    task automatic log_error(input string what);
        $display("ERROR %0t ns: %s", $time, what);
        n_errors++;
    endtask

    task automatic restart_message();
        chain = START_CHAIN;
        blk   = '0;
        fill  = '0;
        nbits = '0;
    endtask

    task automatic absorb_item(input logic [7:0] b, input logic has, input logic last);
        int pos;
        if (has) begin
            blk[8 * fill +: 8] = b;
            fill  = fill + 6'd1;
            nbits = nbits + 64'd8;
            if (fill == 6'd0)
                chain = md5_compress(chain, blk);
        end
        if (last) begin
            pos = int'(fill);
            blk[8 * pos +: 8] = PAD_MARK;
            pos++;
            // no room for the length: finish this block and pad a second one
            if (pos > 56) begin
                while (pos < 64) begin
                    blk[8 * pos +: 8] = 8'h00;
                    pos++;
                end
                chain = md5_compress(chain, blk);
                pos = 0;
            end
            while (pos < 56) begin
                blk[8 * pos +: 8] = 8'h00;
                pos++;
            end
            blk[511:448] = nbits;
            chain = md5_compress(chain, blk);
            digest_q.push_back(chain);
            restart_message();
        end
    endtask

    initial begin
        n_errors  = 0;
        n_pending = 0;
        n_digests = 0;
        restart_message();
    end

    always @(posedge aclk) begin
        md5sh_words_t want;
        md5sh_words_t got;
        if (!aresetn) begin
            restart_message();
            digest_q.delete();
        end else begin
            // result side first: a digest leaving now belongs to an older message
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                n_digests++;
                if (digest_q.size() == 0) begin
                    log_error($sformatf("digest %h with no message pending", m_tdata));
                end else begin
                    want = digest_q.pop_front();
                    for (int i = 0; i < 4; i++)
                        if (got[i] !== want[i])
                            log_error($sformatf("digest_%c got %h expected %h",
                                                8'd97 + i, got[i], want[i]));
                end
            end
            if (s_tvalid && s_tready)
                absorb_item(s_tdata, s_tuser, s_tlast);
        end
        n_pending = digest_q.size();
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the MD5 stream hasher: clock, reset, byte stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 600;
    localparam int ITEM_TARGET = 1400;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;
    logic         s_tuser  = 1'b0;
    logic         s_tlast  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;

    int n_errors, n_pending, n_digests;

    bit calm     = 1'b0;
    bit hold_req = 1'b0;

    int n_items  = 0;
    int n_bytes  = 0;
    int n_ends   = 0;
    int n_idle   = 0;
    int n_msgs   = 0;
    int max_len  = 0;

    always #10 aclk = ~aclk;

    md5_stream_hasher i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    md5_digest_checker i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .n_errors  (n_errors),
        .n_pending (n_pending),
        .n_digests (n_digests)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // mostly short messages, a good share right at the block boundaries
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(0, 8);
        if (r < 80) begin
            case ($urandom_range(0, 9))
                0: return 55;
                1: return 56;
                2: return 57;
                3: return 63;
                4: return 64;
                5: return 65;
                6: return 119;
                7: return 120;
                8: return 127;
                default: return 128;
            endcase
        end
        return $urandom_range(9, 100);
    endfunction

    // valid stays up on return so a back-to-back transfer needs no second assignment
    task automatic send_item(input logic [7:0] b, input logic has, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= has;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (has)
            n_bytes++;
        else if (last)
            n_ends++;
        else
            n_idle++;
        if (has || last)
            n_items++;
    endtask

    task automatic send_message(input int len, input bit split_end);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 29) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, !split_end && k == len - 1);
        end
        if (len == 0 || split_end)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        n_msgs++;
        if (len > max_len)
            max_len = len;
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (n_pending != 0);
    endtask

    // output side: random stalls, occasional long ones, forced hold on request
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (calm) begin
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 199) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(20, 80)) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TIMEOUT: no transfer for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int target;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty message, ignored items, "abc", byte extremes, end-only finish
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        n_msgs += 6;
        pause_until_drained();

        while (n_items < 500)
            send_message(pick_len(), $urandom_range(0, 1));
        pause_until_drained();

        // output held off while short messages keep coming: input must back up
        hold_req = 1'b1;
        calm     = 1'b1;
        repeat (6)
            send_message($urandom_range(0, 3), $urandom_range(0, 1));
        calm = 1'b0;
        pause_until_drained();

        calm   = 1'b1;
        target = n_items + 200;
        while (n_items < target)
            send_message(pick_len(), $urandom_range(0, 1));
        calm = 1'b0;

        while (n_items < ITEM_TARGET || n_msgs < 45)
            send_message(pick_len(), $urandom_range(0, 1));
        pause_until_drained();
        repeat (150) @(negedge aclk);

        $display("Hashed %0d messages: %0d bytes, %0d end-only and %0d ignored items; %0d digests.",
                 n_msgs, n_bytes, n_ends, n_idle, n_digests);
        $display("Lengths from empty to %0d bytes incl. block edges, random stalls, long output hold.",
                 max_len);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
